FILE: rtl/core/pngu_pkg.sv
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared types, constants and the Paeth predictor for the scanline unfilter.
// ----------------------------------------------------------------------------
package pngu_pkg;

  localparam int unsigned MaxRowBytes   = 8192;
  localparam int unsigned MaxPixelBytes = 4;
  localparam int unsigned MaxRows       = 16384;

  localparam int unsigned ColW      = $clog2(MaxRowBytes);
  localparam int unsigned PixIdxW   = $clog2(MaxPixelBytes);
  localparam int unsigned RowIdxW   = 14;
  localparam int unsigned RowBytesW = 14;
  localparam int unsigned BppW      = 3;
  localparam int unsigned RowCountW = 15;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 15;

  typedef enum logic [CfgIdxW-1:0] {
    RegRowBytes      = 2'd0,
    RegBytesPerPixel = 2'd1,
    RegRowCount      = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FiltNone  = 3'd0,
    FiltSub   = 3'd1,
    FiltUp    = 3'd2,
    FiltAvg   = 3'd3,
    FiltPaeth = 3'd4
  } filter_e;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       last_of_image;
    logic       bad_filter;
  } out_item_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] sa;
    logic signed [9:0] sb;
    logic signed [9:0] sc;
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [7:0]        res;
    sa = signed'({2'b00, a});
    sb = signed'({2'b00, b});
    sc = signed'({2'b00, c});
    // distances of p = a + b - c to a, b and c
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - sc - sc;
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) begin
      res = a;
    end else if (db <= dc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/pngu_ifs.sv
// ----------------------------------------------------------------------------
// pngu channel interfaces
// Valid/ready channels for raw bytes, reconstructed bytes and register writes.
// ----------------------------------------------------------------------------
interface pngu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface pngu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       last_of_image;
  logic       bad_filter;

  modport source (output valid, output pixel_byte, output last_of_image,
                  output bad_filter, input ready);
  modport sink   (input valid, input pixel_byte, input last_of_image,
                  input bad_filter, output ready);
endinterface

interface pngu_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pngu_pkg::CfgIdxW-1:0]  index;
  logic [pngu_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/png_scanline_unfilter_top.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top
// PNG scanline filter reconstruction (none, sub, up, average, Paeth).
// ----------------------------------------------------------------------------
// Takes one byte per clock unless the output buffer is full; each reconstructed
// byte enters that buffer when accepted; filter-type bytes give no result. The
// rate is set by the previous-row line store, an 8192 x 8 synchronous RAM with
// one write and one read port: each data byte reads its upper neighbour from
// the read register and writes its result back in the same cycle, while the
// read for the next column is issued, with write-to-read forwarding when both
// hit the same column. A two-entry output buffer keeps input flowing while a
// result waits. The line store is not cleared; the first row of each image
// uses zero for the row above. A filter type above 4 gives one error beat and
// then all input is dropped until reset. Register writes take effect at once.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pngu_in_if.sink    in_i,
  pngu_out_if.source out_o,
  pngu_cfg_if.sink   cfg_i
);

  // configuration
  logic [pngu_pkg::RowBytesW-1:0] row_bytes_q;
  logic [pngu_pkg::BppW-1:0]      bpp_q;
  logic [pngu_pkg::RowCountW-1:0] row_count_q;
  logic [pngu_pkg::RowBytesW-1:0] rb;
  logic [pngu_pkg::BppW-1:0]      bpp_c;
  logic [pngu_pkg::PixIdxW-1:0]   win_idx;
  logic [pngu_pkg::RowCountW-1:0] rc;

  // control state
  logic [pngu_pkg::ColW-1:0]    col_q, col_d;
  logic [pngu_pkg::RowIdxW-1:0] row_q, row_d;
  pngu_pkg::filter_e            filt_q, filt_d;
  logic                         await_q, await_d;
  logic                         first_q, first_d;
  logic                         failed_q, failed_d;

  // neighbor windows and line store
  logic [7:0] left_q [pngu_pkg::MaxPixelBytes];
  logic [7:0] ul_q   [pngu_pkg::MaxPixelBytes];
  logic [7:0] line_mem [pngu_pkg::MaxRowBytes];
  logic [7:0] rd_data_q;
  logic       win_clr;
  logic       win_shift;
  logic       mem_we;

  // datapath
  logic [7:0]                     a, b, c, pred, y;
  logic                           col_end;
  logic [pngu_pkg::RowIdxW:0]     row_next;
  logic                           accept;
  logic                           push;
  pngu_pkg::out_item_t            res;

  // output buffer
  pngu_pkg::out_item_t slot_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          cnt_q;
  logic                pop;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= pngu_pkg::RowBytesW'(1);
      bpp_q       <= pngu_pkg::BppW'(1);
      row_count_q <= pngu_pkg::RowCountW'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pngu_pkg::RegRowBytes:      row_bytes_q <= cfg_i.data[pngu_pkg::RowBytesW-1:0];
        pngu_pkg::RegBytesPerPixel: bpp_q       <= cfg_i.data[pngu_pkg::BppW-1:0];
        pngu_pkg::RegRowCount:      row_count_q <= cfg_i.data[pngu_pkg::RowCountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_bytes_q == '0) begin
      rb = pngu_pkg::RowBytesW'(1);
    end else if (row_bytes_q > pngu_pkg::RowBytesW'(pngu_pkg::MaxRowBytes)) begin
      rb = pngu_pkg::RowBytesW'(pngu_pkg::MaxRowBytes);
    end else begin
      rb = row_bytes_q;
    end
    if (bpp_q == '0) begin
      bpp_c = pngu_pkg::BppW'(1);
    end else if (bpp_q > pngu_pkg::BppW'(pngu_pkg::MaxPixelBytes)) begin
      bpp_c = pngu_pkg::BppW'(pngu_pkg::MaxPixelBytes);
    end else begin
      bpp_c = bpp_q;
    end
    if (row_count_q == '0) begin
      rc = pngu_pkg::RowCountW'(1);
    end else if (row_count_q > pngu_pkg::RowCountW'(pngu_pkg::MaxRows)) begin
      rc = pngu_pkg::RowCountW'(pngu_pkg::MaxRows);
    end else begin
      rc = row_count_q;
    end
  end

  assign win_idx = pngu_pkg::PixIdxW'(bpp_c - pngu_pkg::BppW'(1));

  // --------------------------------------------------------------------------
  // Reconstruction
  // --------------------------------------------------------------------------
  assign in_i.ready = (cnt_q != 2'd2);
  assign accept     = in_i.valid && in_i.ready;

  assign a = left_q[win_idx];
  assign c = ul_q[win_idx];
  assign b = first_q ? 8'd0 : rd_data_q;

  always_comb begin
    case (filt_q)
      pngu_pkg::FiltNone:  pred = 8'd0;
      pngu_pkg::FiltSub:   pred = a;
      pngu_pkg::FiltUp:    pred = b;
      pngu_pkg::FiltAvg:   pred = 8'(({1'b0, a} + {1'b0, b}) >> 1);
      pngu_pkg::FiltPaeth: pred = pngu_pkg::paeth(a, b, c);
      default:             pred = 8'd0;
    endcase
  end

  assign y        = in_i.data_byte + pred;
  assign col_end  = ({1'b0, col_q} + pngu_pkg::RowBytesW'(1)) >= rb;
  assign row_next = {1'b0, row_q} + (pngu_pkg::RowIdxW + 1)'(1);

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    filt_d    = filt_q;
    await_d   = await_q;
    first_d   = first_q;
    failed_d  = failed_q;
    win_clr   = 1'b0;
    win_shift = 1'b0;
    mem_we    = 1'b0;
    push      = 1'b0;
    res       = '0;
    if (accept && !failed_q) begin
      if (await_q) begin
        if (in_i.data_byte > 8'(pngu_pkg::FiltPaeth)) begin
          failed_d          = 1'b1;
          push              = 1'b1;
          res.last_of_image = 1'b1;
          res.bad_filter    = 1'b1;
        end else begin
          filt_d  = pngu_pkg::filter_e'(in_i.data_byte[2:0]);
          await_d = 1'b0;
          col_d   = '0;
          win_clr = 1'b1;
        end
      end else begin
        mem_we         = 1'b1;
        win_shift      = 1'b1;
        push           = 1'b1;
        res.pixel_byte = y;
        col_d          = col_q + pngu_pkg::ColW'(1);
        if (col_end) begin
          await_d = 1'b1;
          first_d = 1'b0;
          col_d   = '0;
          if (row_next >= rc) begin
            res.last_of_image = 1'b1;
            row_d             = '0;
            first_d           = 1'b1;
          end else begin
            row_d = row_next[pngu_pkg::RowIdxW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      filt_q   <= pngu_pkg::FiltNone;
      await_q  <= 1'b1;
      first_q  <= 1'b1;
      failed_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      filt_q   <= filt_d;
      await_q  <= await_d;
      first_q  <= first_d;
      failed_q <= failed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < pngu_pkg::MaxPixelBytes; k++) begin
        left_q[k] <= '0;
        ul_q[k]   <= '0;
      end
    end else if (win_clr) begin
      for (int k = 0; k < pngu_pkg::MaxPixelBytes; k++) begin
        left_q[k] <= '0;
        ul_q[k]   <= '0;
      end
    end else if (win_shift) begin
      for (int k = pngu_pkg::MaxPixelBytes - 1; k > 0; k--) begin
        left_q[k] <= left_q[k-1];
        ul_q[k]   <= ul_q[k-1];
      end
      left_q[0] <= y;
      ul_q[0]   <= b;
    end
  end

  // Read ahead at the next column; forward the write when it hits that column.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[col_q] <= y;
    end
    if (mem_we && (col_q == col_d)) begin
      rd_data_q <= y;
    end else begin
      rd_data_q <= line_mem[col_d];
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer
  // --------------------------------------------------------------------------
  assign pop                 = (cnt_q != 2'd0) && out_o.ready;
  assign out_o.valid         = (cnt_q != 2'd0);
  assign out_o.pixel_byte    = slot_q[rd_ptr_q].pixel_byte;
  assign out_o.last_of_image = slot_q[rd_ptr_q].last_of_image;
  assign out_o.bad_filter    = slot_q[rd_ptr_q].bad_filter;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/core/pngu_checker.sv
// ----------------------------------------------------------------------------
// pngu_checker
// Port-level checks for the scanline unfilter, bound to the top level.
// ----------------------------------------------------------------------------
module pngu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_pixel_byte_i,
  input logic       out_last_i,
  input logic       out_bad_i
);

  logic out_beat;
  logic bad_seen_q;

  assign out_beat = out_valid_i && out_ready_i;

  // remember an accepted error beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_seen_q <= 1'b0;
    end else if (out_beat && out_bad_i) begin
      bad_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_rise_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result appeared without an input beat");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  a_error_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && out_bad_i |-> out_last_i && (out_pixel_byte_i == 8'd0))
    else $error("malformed error beat");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_seen_q |-> !out_valid_i)
    else $error("result after error beat");

endmodule

bind png_scanline_unfilter_top pngu_checker u_pngu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_pixel_byte_i (out_o.pixel_byte),
  .out_last_i       (out_o.last_of_image),
  .out_bad_i        (out_o.bad_filter)
);
